// ----- hdl/tlc_pkg.sv -----
// Shared types and constants for the two-level cache tag lookup.
// No dependencies; every other file in hdl/ except tlc_stream_if refers to this package by scoped names.
package tlc_pkg;

    localparam int ADDR_BITS = 32;

    // Default geometry, handed down from the top level
    localparam int L1_OFFSET_BITS = 4;
    localparam int L1_WAYS        = 4;
    localparam int L1_INDEX_BITS  = 6;
    localparam int L2_OFFSET_BITS = 4;
    localparam int L2_WAYS        = 8;
    localparam int L2_INDEX_BITS  = 9;

    typedef enum logic [2:0] {
        STAT_NONE       = 3'd0,
        STAT_READ_HIT   = 3'd1,
        STAT_READ_MISS  = 3'd2,
        STAT_WRITE_HIT  = 3'd3,
        STAT_WRITE_MISS = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;    // write one zeroed row into each tag memory
        logic capture;  // item accepted: latch it, read both tag rows
        logic commit;   // write back fills, load output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pass at its final row
        logic out_free; // output register empty or being drained
    } t_sts;

endpackage

// ----- hdl/tlc_stream_if.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on nothing; port widths follow the address and status codes.
interface tlc_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

interface tlc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] l1_status;
    logic [2:0] l2_status;

    modport source (output valid, output l1_status, output l2_status, input ready);
    modport sink   (input valid, input l1_status, input l2_status, output ready);
endinterface

// ----- hdl/tlc_tag_store.sv -----
// One level of set-associative tag storage: row memory, tag compare and fill.
// Depends on tlc_pkg. Row = {victim pointer, valid bits, tags}.
module tlc_tag_store #(
    parameter int OFFSET_BITS = tlc_pkg::L1_OFFSET_BITS,
    parameter int INDEX_BITS  = tlc_pkg::L1_INDEX_BITS,
    parameter int WAYS        = tlc_pkg::L1_WAYS,
    parameter int CLR_W       = tlc_pkg::L1_INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [tlc_pkg::ADDR_BITS-1:0] i_rd_addr,
    input  logic [tlc_pkg::ADDR_BITS-1:0] i_look_addr,
    input  logic                          i_fill,
    input  logic                          i_clear,
    input  logic [CLR_W-1:0]              i_clr_set,
    output logic                          o_hit
);

    localparam int SETS  = 1 << INDEX_BITS;
    localparam int TAG_W = tlc_pkg::ADDR_BITS - INDEX_BITS - OFFSET_BITS;
    localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAGS_W = WAYS * TAG_W;
    localparam int ROW_W = PTR_W + WAYS + TAGS_W;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] r_row;

    logic [INDEX_BITS-1:0] rd_set;
    logic [INDEX_BITS-1:0] look_set;
    logic [INDEX_BITS-1:0] wr_set;
    logic [TAG_W-1:0]      look_tag;
    logic [PTR_W-1:0]      row_ptr;
    logic [WAYS-1:0]       row_valid;
    logic                  free_found;
    logic [PTR_W-1:0]      free_way;
    logic [PTR_W:0]        victim;
    logic [PTR_W:0]        victim_inc;
    logic [PTR_W-1:0]      sel_way;
    logic [ROW_W-1:0]      fill_row;
    logic [ROW_W-1:0]      wr_row;
    logic                  wr_en;

    assign rd_set   = i_rd_addr[OFFSET_BITS +: INDEX_BITS];
    assign look_set = i_look_addr[OFFSET_BITS +: INDEX_BITS];
    assign look_tag = i_look_addr[tlc_pkg::ADDR_BITS-1 -: TAG_W];
    assign row_ptr   = r_row[ROW_W-1 -: PTR_W];
    assign row_valid = r_row[TAGS_W +: WAYS];

    always_comb begin
        o_hit = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (row_valid[w] && (r_row[w*TAG_W +: TAG_W] == look_tag)) begin
                o_hit = 1'b1;
            end
        end
    end

    // Lowest invalid way
    always_comb begin
        free_found = 1'b0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!row_valid[w]) begin
                free_found = 1'b1;
                free_way   = PTR_W'(w);
            end
        end
    end

    // Round-robin victim with wrap
    always_comb begin
        victim = {1'b0, row_ptr};
        if (victim >= (PTR_W+1)'(WAYS)) begin
            victim = '0;
        end
        victim_inc = victim + (PTR_W+1)'(1);
        if (victim_inc >= (PTR_W+1)'(WAYS)) begin
            victim_inc = '0;
        end
    end

    assign sel_way = free_found ? free_way : victim[PTR_W-1:0];

    always_comb begin
        fill_row = r_row;
        for (int w = 0; w < WAYS; w++) begin
            if (PTR_W'(w) == sel_way) begin
                fill_row[w*TAG_W +: TAG_W] = look_tag;
                fill_row[TAGS_W + w]       = 1'b1;
            end
        end
        if (!free_found) begin
            fill_row[ROW_W-1 -: PTR_W] = victim_inc[PTR_W-1:0];
        end
    end

    assign wr_en  = i_clear || i_fill;
    assign wr_set = i_clear ? i_clr_set[INDEX_BITS-1:0] : look_set;
    assign wr_row = i_clear ? '0 : fill_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_set] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_row <= mem[rd_set];
        end
    end

endmodule

// ----- hdl/tlc_datapath.sv -----
// Datapath: item register, both tag stores, clear counter, result register.
// Depends on tlc_pkg and tlc_tag_store.
module tlc_datapath #(
    parameter int L1_OFFSET_BITS = tlc_pkg::L1_OFFSET_BITS,
    parameter int L1_WAYS        = tlc_pkg::L1_WAYS,
    parameter int L1_INDEX_BITS  = tlc_pkg::L1_INDEX_BITS,
    parameter int L2_OFFSET_BITS = tlc_pkg::L2_OFFSET_BITS,
    parameter int L2_WAYS        = tlc_pkg::L2_WAYS,
    parameter int L2_INDEX_BITS  = tlc_pkg::L2_INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlc_pkg::t_cmd                 i_cmd,
    output tlc_pkg::t_sts                 o_sts,
    input  logic                          i_operation,
    input  logic [tlc_pkg::ADDR_BITS-1:0] i_address,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [2:0]                    o_l1_status,
    output logic [2:0]                    o_l2_status
);

    localparam int CLR_W = (L1_INDEX_BITS > L2_INDEX_BITS) ? L1_INDEX_BITS : L2_INDEX_BITS;

    logic                          r_op;
    logic [tlc_pkg::ADDR_BITS-1:0] r_addr;
    logic [CLR_W-1:0]              r_clr_set;
    logic                          r_out_valid;
    tlc_pkg::t_status              r_l1_status;
    tlc_pkg::t_status              r_l2_status;
    tlc_pkg::t_status              n_l1_status;
    tlc_pkg::t_status              n_l2_status;
    logic                          l1_hit;
    logic                          l2_hit;
    logic                          l1_fill;
    logic                          l2_fill;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_addr <= i_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_set <= '0;
        end else if (i_cmd.clear) begin
            r_clr_set <= r_clr_set + CLR_W'(1);
        end
    end

    // Reads only miss-allocate; L2 fills only when it misses too
    assign l1_fill = i_cmd.commit && !r_op && !l1_hit;
    assign l2_fill = l1_fill && !l2_hit;

    tlc_tag_store #(
        .OFFSET_BITS (L1_OFFSET_BITS),
        .INDEX_BITS  (L1_INDEX_BITS),
        .WAYS        (L1_WAYS),
        .CLR_W       (CLR_W)
    ) u_l1 (
        .i_clk       (i_clk),
        .i_rd_en     (i_cmd.capture),
        .i_rd_addr   (i_address),
        .i_look_addr (r_addr),
        .i_fill      (l1_fill),
        .i_clear     (i_cmd.clear),
        .i_clr_set   (r_clr_set),
        .o_hit       (l1_hit)
    );

    tlc_tag_store #(
        .OFFSET_BITS (L2_OFFSET_BITS),
        .INDEX_BITS  (L2_INDEX_BITS),
        .WAYS        (L2_WAYS),
        .CLR_W       (CLR_W)
    ) u_l2 (
        .i_clk       (i_clk),
        .i_rd_en     (i_cmd.capture),
        .i_rd_addr   (i_address),
        .i_look_addr (r_addr),
        .i_fill      (l2_fill),
        .i_clear     (i_cmd.clear),
        .i_clr_set   (r_clr_set),
        .o_hit       (l2_hit)
    );

    always_comb begin
        if (r_op) begin
            n_l1_status = l1_hit ? tlc_pkg::STAT_WRITE_HIT : tlc_pkg::STAT_WRITE_MISS;
            n_l2_status = l2_hit ? tlc_pkg::STAT_WRITE_HIT : tlc_pkg::STAT_WRITE_MISS;
        end else begin
            n_l1_status = l1_hit ? tlc_pkg::STAT_READ_HIT : tlc_pkg::STAT_READ_MISS;
            n_l2_status = l2_hit ? tlc_pkg::STAT_READ_HIT : tlc_pkg::STAT_READ_MISS;
        end
        if (l1_hit) begin
            n_l2_status = tlc_pkg::STAT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_l1_status <= n_l1_status;
            r_l2_status <= n_l2_status;
        end
    end

    assign o_sts.clr_last = (r_clr_set == {CLR_W{1'b1}});
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_l1_status    = r_l1_status;
    assign o_l2_status    = r_l2_status;

endmodule

// ----- hdl/tlc_ctrl.sv -----
// Controller: clearing pass after reset, then accept / lookup sequencing.
// Depends on tlc_pkg.
module tlc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tlc_pkg::t_sts i_sts,
    output logic          o_ready,
    output tlc_pkg::t_cmd o_cmd
);

    tlc_pkg::t_state r_state;
    tlc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_cmd.clear   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            tlc_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = tlc_pkg::S_IDLE;
                end
            end
            tlc_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_state = tlc_pkg::S_LOOKUP;
                end
            end
            tlc_pkg::S_LOOKUP: begin
                // hold the read row until the result slot is free
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = tlc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/two_level_cache_tag_lookup_top.sv -----
// Top level of the two-level cache tag lookup.
// Depends on tlc_pkg, tlc_stream_if, tlc_ctrl and tlc_datapath.
//
//   Channel  Dir  Modport  Payload                       Item accepted when
//   i_req    in   sink     operation[0], address[31:0]   valid && ready
//   o_rsp    out  source   l1_status[2:0], l2_status[2:0] valid && ready
//
// Per item: in the accept cycle both tag memories are read at the item's set;
// in the lookup state that follows, tags are compared, any fills written back
// and the result loaded once the output register is free. Each tag memory has
// one read and one write port; a fill lands before the next item is accepted.
// Reset: synchronous, active low, then a clearing pass over 2**max(index bits)
// row addresses (512 at default geometry) zeroes valid bits and victim pointers;
// ready stays low throughout.
// Stalls: a result waits in the output register; the next item is taken
// meanwhile and holds in lookup until that register drains.
module two_level_cache_tag_lookup_top #(
    parameter int L1_OFFSET_BITS = tlc_pkg::L1_OFFSET_BITS,
    parameter int L1_WAYS        = tlc_pkg::L1_WAYS,
    parameter int L1_INDEX_BITS  = tlc_pkg::L1_INDEX_BITS,
    parameter int L2_OFFSET_BITS = tlc_pkg::L2_OFFSET_BITS,
    parameter int L2_WAYS        = tlc_pkg::L2_WAYS,
    parameter int L2_INDEX_BITS  = tlc_pkg::L2_INDEX_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlc_req_if.sink   i_req,
    tlc_rsp_if.source o_rsp
);

    tlc_pkg::t_cmd cmd;
    tlc_pkg::t_sts sts;
    logic          ready;

    // Sequencer: clear pass, accept, lookup/commit
    tlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    assign i_req.ready = ready;

    // Tag stores, item register and result register
    tlc_datapath #(
        .L1_OFFSET_BITS (L1_OFFSET_BITS),
        .L1_WAYS        (L1_WAYS),
        .L1_INDEX_BITS  (L1_INDEX_BITS),
        .L2_OFFSET_BITS (L2_OFFSET_BITS),
        .L2_WAYS        (L2_WAYS),
        .L2_INDEX_BITS  (L2_INDEX_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_req.operation),
        .i_address   (i_req.address),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_l1_status (o_rsp.l1_status),
        .o_l2_status (o_rsp.l2_status)
    );

`ifndef SYNTHESIS
    // No item is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_req.ready)
        else $error("item accepted during clearing pass");

    // A result is never loaded over one that has not been taken
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten");

    // An accepted item blocks the next accept while it is in lookup
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second item accepted during lookup");

    // An L1 hit reports the L2 status as none
    a_l1_hit_l2_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.l1_status == tlc_pkg::STAT_READ_HIT ||
                         o_rsp.l1_status == tlc_pkg::STAT_WRITE_HIT))
        |-> (o_rsp.l2_status == tlc_pkg::STAT_NONE))
        else $error("L2 status set on an L1 hit");
`endif

endmodule
